// ----- design/spfa_pkg.sv -----
// Shared types and constants of the shortest-path engine.
package spfa_pkg;

  localparam int unsigned NODE_W  = 10;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COST_W  = 16;
  localparam int unsigned OUT_D_W = 48;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned CQ_DEPTH = 4;

  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_RUN,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [NODE_W-1:0]        end_a;
    logic [NODE_W-1:0]        end_b;
    logic signed [COST_W-1:0] weight;
    logic [NODE_W-1:0]        source_node;
    logic [NODE_W-1:0]        dest_node;
  } req_t;

  typedef struct packed {
    logic signed [OUT_D_W-1:0] distance;
    logic                      reachable;
    logic                      negative_cycle;
    logic                      edges_dropped;
  } rsp_t;

  // Decoded request as it sits in the command queue. For a run, node_a is the
  // source and node_b the destination.
  typedef struct packed {
    op_e                      op;
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic signed [COST_W-1:0] weight;
  } cmd_t;

  // One stored undirected edge; it stands for a->b and then b->a.
  typedef struct packed {
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic signed [COST_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic valid;
    cmd_t head;
  } cq_head_t;

endpackage

// ----- design/spfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module spfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/spfa_front.sv -----
// Request intake: decodes commands, drops unknown ones and buffers the rest in a short queue.
module spfa_front
  import spfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  req_t     req_i,
  output cq_head_t cq_o,
  input  logic     cq_pop_i
);

  localparam int unsigned PW = $clog2(CQ_DEPTH);

  cmd_t           q_q [CQ_DEPTH];
  logic [PW-1:0]  wp_q, rp_q;
  logic [PW:0]    cnt_q;
  logic           take, known;
  cmd_t           dec;

  assign full = (cnt_q == (PW+1)'(CQ_DEPTH));
  assign take = push && !full;

  always_comb begin
    dec.node_a = req_i.end_a;
    dec.node_b = req_i.end_b;
    dec.weight = req_i.weight;
    known      = 1'b1;
    case (req_i.cmd)
      CMD_ADD: begin
        dec.op = OP_ADD;
      end
      CMD_RUN: begin
        dec.op     = OP_RUN;
        dec.node_a = req_i.source_node;
        dec.node_b = req_i.dest_node;
      end
      CMD_CLEAR: begin
        dec.op = OP_CLEAR;
      end
      default: begin
        dec.op = OP_CLEAR;
        known  = 1'b0;
      end
    endcase
  end

  assign cq_o.valid = (cnt_q != '0);
  assign cq_o.head  = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (take && known) begin
      q_q[wp_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (take && known) begin
        wp_q <= wp_q + 1'b1;
      end
      if (cq_pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(take && known) - (PW+1)'(cq_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(CQ_DEPTH))
    else $error("command queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_pop_i |-> cq_o.valid)
    else $error("command queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && known && !cq_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("decoded command not queued");

endmodule

// ----- design/spfa_back.sv -----
// Command executor: edge store upkeep and the queue-based relaxation walk.
module spfa_back
  import spfa_pkg::*;
#(
  parameter int unsigned MAX_NODES          = 1024,
  parameter int unsigned MAX_DIRECTED_EDGES = 8192,
  parameter int unsigned DIST_BITS          = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cq_head_t         cq_i,
  output logic             cq_pop_o,
  input  logic [CNT_W-1:0] node_count_i,
  output logic             rsp_valid_o,
  output rsp_t             rsp_o,
  input  logic             rsp_pop_i
);

  localparam int unsigned NB    = $clog2(MAX_NODES);
  localparam int unsigned CW    = (NB + 1 > CNT_W) ? NB + 1 : CNT_W;
  localparam int unsigned PAIRS = MAX_DIRECTED_EDGES / 2;
  localparam int unsigned FW    = $clog2(PAIRS + 1);
  localparam int unsigned EAW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int unsigned DB    = DIST_BITS;

  typedef struct packed {
    logic signed [DB-1:0] path_len;
    logic                 reached;
    logic                 mark;
    logic [NB:0]          tally;
  } node_t;

  localparam int unsigned NW = $bits(node_t);
  localparam int unsigned EW = $bits(edge_t);

  localparam logic signed [DB-1:0] DMAX = {1'b0, {(DB-1){1'b1}}};
  localparam logic signed [DB-1:0] DMIN = {1'b1, {(DB-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SEED, S_POP, S_POPW, S_UREAD, S_EREQ, S_EWAIT,
    S_ECHK, S_NWAIT, S_FIN, S_FINW
  } state_e;

  state_e               state_q;
  logic [FW-1:0]        fill_q, k_q;
  logic                 ovf_q, neg_q, dir_q, out_valid_q;
  logic [NODE_W-1:0]    src_q, dst_q;
  logic [CW-1:0]        limit_q, limit_d;
  logic [NB-1:0]        idx_q, head_q, tail_q, u_q, v_q;
  logic [NB:0]          wcnt_q;
  logic signed [DB-1:0] du_q, cand_q, cand_d;
  edge_t                edge_q;
  rsp_t                 out_q;
  logic                 fin_load;

  // Memory ports.
  logic          n_we, n_re, w_we, w_re, e_we, e_re;
  logic [NB-1:0] n_waddr, n_raddr;
  node_t         n_wdata, n_rdata;
  logic [NW-1:0] n_rbits;
  logic [NB-1:0] w_rdata;
  logic [EW-1:0] e_rbits;
  edge_t         e_wdata;

  // Edge direction under test.
  logic [NODE_W-1:0] from_n, to_n;
  logic              edge_ok, src_ok, dst_ok, upd, hit_limit;
  logic [NB:0]       tally_inc;
  logic [DB:0]       sum;
  logic              push_ok;

  assign n_rdata = node_t'(n_rbits);
  assign limit_d = (CW'(node_count_i) > CW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                         : CW'(node_count_i);
  assign src_ok  = CW'(src_q) < limit_q;
  assign dst_ok  = CW'(dst_q) < limit_q;
  assign from_n  = dir_q ? edge_q.node_b : edge_q.node_a;
  assign to_n    = dir_q ? edge_q.node_a : edge_q.node_b;
  assign edge_ok = (CW'(from_n) < limit_q) && (CW'(to_n) < limit_q)
                   && (CW'(from_n) == CW'(u_q));

  // Saturating candidate distance.
  assign sum = {du_q[DB-1], du_q} + (DB+1)'(signed'(edge_q.weight));
  always_comb begin
    if (sum[DB] != sum[DB-1]) begin
      cand_d = edge_q.weight[COST_W-1] ? DMIN : DMAX;
    end else begin
      cand_d = sum[DB-1:0];
    end
  end

  assign upd       = !n_rdata.reached || (n_rdata.path_len > cand_q);
  assign tally_inc = n_rdata.tally + 1'b1;
  assign hit_limit = CW'(tally_inc) >= limit_q;
  assign push_ok   = upd && !n_rdata.mark;
  assign cq_pop_o  = (state_q == S_IDLE) && cq_i.valid;
  assign fin_load  = (state_q == S_FINW) && (!out_valid_q || rsp_pop_i);

  always_comb begin
    n_we    = 1'b0;
    n_waddr = idx_q;
    n_wdata = '0;
    n_re    = 1'b0;
    n_raddr = v_q;
    w_we    = 1'b0;
    w_re    = 1'b0;
    e_re    = 1'b0;
    e_we    = cq_pop_o && (cq_i.head.op == OP_ADD) && (fill_q != FW'(PAIRS));
    e_wdata.node_a = cq_i.head.node_a;
    e_wdata.node_b = cq_i.head.node_b;
    e_wdata.weight = cq_i.head.weight;
    case (state_q)
      S_CLR: begin
        n_we = 1'b1;
      end
      S_SEED: begin
        n_we            = src_ok;
        n_waddr         = NB'(src_q);
        n_wdata.reached = 1'b1;
        n_wdata.mark    = 1'b1;
        w_we            = src_ok;
      end
      S_POP: begin
        w_re = (wcnt_q != '0);
      end
      S_POPW: begin
        n_re    = 1'b1;
        n_raddr = w_rdata;
      end
      S_UREAD: begin
        n_we         = 1'b1;
        n_waddr      = u_q;
        n_wdata      = n_rdata;
        n_wdata.mark = 1'b0;
      end
      S_EREQ: begin
        e_re = (k_q != fill_q);
      end
      S_ECHK: begin
        n_re    = edge_ok;
        n_raddr = NB'(to_n);
      end
      S_NWAIT: begin
        n_we             = upd;
        n_waddr          = v_q;
        n_wdata          = n_rdata;
        n_wdata.path_len = cand_q;
        n_wdata.reached  = 1'b1;
        if (push_ok) begin
          n_wdata.mark  = 1'b1;
          n_wdata.tally = tally_inc;
        end
        w_we = push_ok;
      end
      S_FIN: begin
        n_re    = 1'b1;
        n_raddr = NB'(dst_q);
      end
      default: begin
      end
    endcase
  end

  spfa_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (n_re),
    .raddr_i (n_raddr),
    .rdata_o (n_rbits)
  );

  spfa_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (tail_q),
    .wdata_i ((state_q == S_SEED) ? NB'(src_q) : v_q),
    .re_i    (w_re),
    .raddr_i (head_q),
    .rdata_o (w_rdata)
  );

  spfa_ram #(.WIDTH(EW), .DEPTH(PAIRS)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (fill_q[EAW-1:0]),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (k_q[EAW-1:0]),
    .rdata_o (e_rbits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      wcnt_q      <= '0;
      k_q         <= '0;
      dir_q       <= 1'b0;
      limit_q     <= '0;
    end else begin
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_pop_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cq_i.valid) begin
            case (cq_i.head.op)
              OP_ADD: begin
                if (fill_q != FW'(PAIRS)) begin
                  fill_q <= fill_q + 1'b1;
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OP_CLEAR: begin
                fill_q <= '0;
                ovf_q  <= 1'b0;
              end
              OP_RUN: begin
                src_q   <= cq_i.head.node_a;
                dst_q   <= cq_i.head.node_b;
                limit_q <= limit_d;
                neg_q   <= 1'b0;
                idx_q   <= '0;
                head_q  <= '0;
                tail_q  <= '0;
                wcnt_q  <= '0;
                state_q <= S_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == NB'(MAX_NODES - 1)) begin
            state_q <= S_SEED;
          end
        end
        S_SEED: begin
          if (src_ok) begin
            tail_q  <= NB'(1);
            wcnt_q  <= (NB+1)'(1);
            state_q <= S_POP;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_POP: begin
          if (wcnt_q == '0) begin
            state_q <= S_FIN;
          end else begin
            head_q  <= (head_q == NB'(MAX_NODES - 1)) ? '0 : head_q + 1'b1;
            wcnt_q  <= wcnt_q - 1'b1;
            state_q <= S_POPW;
          end
        end
        S_POPW: begin
          u_q     <= w_rdata;
          state_q <= S_UREAD;
        end
        S_UREAD: begin
          du_q    <= n_rdata.path_len;
          k_q     <= '0;
          state_q <= S_EREQ;
        end
        S_EREQ: begin
          state_q <= (k_q == fill_q) ? S_POP : S_EWAIT;
        end
        S_EWAIT: begin
          edge_q  <= edge_t'(e_rbits);
          dir_q   <= 1'b0;
          state_q <= S_ECHK;
        end
        S_ECHK: begin
          if (edge_ok) begin
            cand_q  <= cand_d;
            v_q     <= NB'(to_n);
            state_q <= S_NWAIT;
          end else if (!dir_q) begin
            dir_q <= 1'b1;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_EREQ;
          end
        end
        S_NWAIT: begin
          if (upd && (v_q == u_q)) begin
            du_q <= cand_q;
          end
          if (push_ok) begin
            tail_q <= (tail_q == NB'(MAX_NODES - 1)) ? '0 : tail_q + 1'b1;
            wcnt_q <= wcnt_q + 1'b1;
          end
          if (push_ok && hit_limit) begin
            neg_q   <= 1'b1;
            state_q <= S_FIN;
          end else if (!dir_q) begin
            dir_q   <= 1'b1;
            state_q <= S_ECHK;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_EREQ;
          end
        end
        S_FIN: begin
          state_q <= S_FINW;
        end
        S_FINW: begin
          if (fin_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload; only loaded when the result register is free.
  logic signed [63:0] dist_ext;
  logic               reach;
  assign reach    = !neg_q && dst_ok && n_rdata.reached;
  assign dist_ext = n_rdata.path_len;

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_q.distance       <= reach ? dist_ext[OUT_D_W-1:0] : '0;
      out_q.reachable      <= reach;
      out_q.negative_cycle <= neg_q;
      out_q.edges_dropped  <= ovf_q;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= (NB+1)'(MAX_NODES))
    else $error("work queue exceeded node capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(PAIRS))
    else $error("edge fill beyond store depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINW))
    else $error("result raised outside run completion");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_pop_o |-> state_q == S_IDLE)
    else $error("command taken while a run is active");

endmodule

// ----- design/spfa_shortest_path_engine.sv -----
// Top level of the queue-based Bellman-Ford shortest-path engine.
// Operation: an add or clear request is done while the executor stays idle; a run wipes the
//   node table and seeds the source, then for each dequeued node scans every stored edge pair
//   both ways, relaxes matching directions, and finishes once the result register is free.
// Throughput: adds flow one per cycle; a run holds the executor, and requests behind it pile
//   into the four-entry command queue until full rises. Reset: asynchronous active low;
//   empties both queues, edge fill and overflow flag, and sets node_count to 1024.
module spfa_shortest_path_engine
  import spfa_pkg::*;
#(
  parameter int unsigned MAX_NODES          = 1024,
  parameter int unsigned MAX_DIRECTED_EDGES = 8192,
  parameter int unsigned DIST_BITS          = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  req_t             req_i,
  output logic             empty,
  input  logic             pop,
  output rsp_t             rsp_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  // The node count register also serves as the negative-cycle push limit.
  logic [CNT_W-1:0] node_count_q;
  cq_head_t         cq;
  logic             cq_pop;
  logic             rsp_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  // The front end decodes each request and parks it in a short queue, so a
  // long run in the executor does not block the input side right away.
  spfa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .req_i    (req_i),
    .cq_o     (cq),
    .cq_pop_i (cq_pop)
  );

  // The executor owns the edge store, the node table and the work queue. Its
  // result register decouples it from the consumer.
  spfa_back #(
    .MAX_NODES          (MAX_NODES),
    .MAX_DIRECTED_EDGES (MAX_DIRECTED_EDGES),
    .DIST_BITS          (DIST_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cq_i         (cq),
    .cq_pop_o     (cq_pop),
    .node_count_i (node_count_q),
    .rsp_valid_o  (rsp_valid),
    .rsp_o        (rsp_o),
    .rsp_pop_i    (pop && rsp_valid)
  );

  assign empty = !rsp_valid;

endmodule
